### rtl/rwoc_pkg.sv
// shared types and constants of the reserved window overlap checker
`timescale 1ns / 1ps

package rwoc_pkg;

    localparam int ENTRY_W = 3;
    localparam int COUNT_W = 4;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    localparam logic [1:0] REASON_NONE   = 2'd0;
    localparam logic [1:0] REASON_WRAP   = 2'd1;
    localparam logic [1:0] REASON_DIRECT = 2'd2;
    localparam logic [1:0] REASON_ALIAS  = 2'd3;

    localparam logic [31:0] PERI_FIRST  = 32'h4000_0000;
    localparam logic [31:0] PERI_LAST   = 32'h400F_FFFF;
    localparam logic [31:0] ALIAS_FIRST = 32'h4200_0000;

    localparam logic REG_BITBAND = 1'b0;
    localparam logic REG_COUNT   = 1'b1;

    // one table entry after its bounds are worked out
    typedef struct packed {
        logic        live;
        logic        in_region;
        logic [31:0] first;
        logic [31:0] last;
        logic [31:0] a_first;
        logic [31:0] a_last;
    } t_blk;

endpackage

### rtl/rwoc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module rwoc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/reserved_window_overlap_checker.sv
// reserved window overlap checker top level
`timescale 1ns / 1ps

// Holds up to MAX_BLOCKS reserved blocks (base, size) in one ram. A load item
// (func 0) writes one entry in the cycle it is accepted and gives no result;
// an entry_index of MAX_BLOCKS or more is dropped. A check item (func 1) gives
// one result: empty windows never hit, windows that wrap past 2^32 hit with
// reason 1, else the table entries below block_count are walked in order
// through a read / bound / compare pipeline, direct overlap (reason 2) tested
// before the bit-band alias image (reason 3), stopping at the first hit. One
// item is in work at a time; the walk is paced by the single read port of the
// table ram. Results sit in an output register, so a new item is taken while
// the last result waits. bitband_enable is at byte address 0 and block_count
// at 4; write them only while no item is open.

module reserved_window_overlap_checker #(
    parameter int MAX_BLOCKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [2:0]  i_entry_index,
    input  logic [31:0] i_window_base,
    input  logic [31:0] i_window_size,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_hits_reserved,
    output logic [1:0]  o_hit_reason,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > rwoc_pkg::COUNT_W) ? CNT_W : rwoc_pkg::COUNT_W;
    localparam int XW    = (AW > rwoc_pkg::ENTRY_W) ? AW : rwoc_pkg::ENTRY_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // configuration
    logic                         r_bitband;
    logic [rwoc_pkg::COUNT_W-1:0] r_block_count;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitband     <= 1'b0;
            r_block_count <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == rwoc_pkg::REG_BITBAND) begin
                r_bitband <= pwdata[0];
            end else begin
                r_block_count <= pwdata[rwoc_pkg::COUNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == rwoc_pkg::REG_COUNT) begin
            prdata = {{(32 - rwoc_pkg::COUNT_W){1'b0}}, r_block_count};
        end else begin
            prdata = {31'b0, r_bitband};
        end
    end

    // control state
    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_issue, n_issue;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_v1, n_v1;
    logic             r_v2, n_v2;
    logic             r_t1_last, r_t2_last;
    logic [1:0]       r_reason, n_reason;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_out_reason, n_out_reason;
    logic [31:0]      r_w_first, r_w_last;

    logic in_acc;
    logic is_check;
    logic [32:0] w_end;
    logic [CMP_W-1:0] bc_x, max_x, eff_x;
    logic [CNT_W-1:0] eff_count;
    logic [XW-1:0] idx_x;
    logic ram_we;
    logic rd_en;
    logic issue_last;
    logic out_free;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_check   = (i_func == rwoc_pkg::FUNC_CHECK);
    assign w_end      = {1'b0, i_window_base} + {1'b0, i_window_size} - 33'd1;

    assign bc_x      = CMP_W'(r_block_count);
    assign max_x     = CMP_W'(MAX_BLOCKS);
    assign eff_x     = (bc_x > max_x) ? max_x : bc_x;
    assign eff_count = eff_x[CNT_W-1:0];

    assign idx_x  = XW'(i_entry_index);
    assign ram_we = in_acc && !is_check && (32'(i_entry_index) < MAX_BLOCKS);

    // table ram: {base, size}
    logic [63:0] rd_data;

    rwoc_ram #(
        .WIDTH (64),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_x[AW-1:0]),
        .i_wdata ({i_window_base, i_window_size}),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (rd_data)
    );

    // bound stage: entry limits and its alias image
    rwoc_pkg::t_blk blk_c, r_blk;
    logic [31:0] b_base, b_size;
    logic [32:0] b_end;

    assign b_base = rd_data[63:32];
    assign b_size = rd_data[31:0];
    assign b_end  = {1'b0, b_base} + {1'b0, b_size} - 33'd1;

    always_comb begin
        blk_c.live      = (b_size != '0);
        blk_c.first     = b_base;
        // an entry running past the top reaches the last address only
        blk_c.last      = b_end[32] ? 32'hFFFF_FFFF : b_end[31:0];
        blk_c.in_region = (b_base >= rwoc_pkg::PERI_FIRST)
                          && !b_end[32] && (b_end[31:0] <= rwoc_pkg::PERI_LAST);
        blk_c.a_first   = rwoc_pkg::ALIAS_FIRST + {7'b0, b_base[19:0], 5'b0};
        blk_c.a_last    = rwoc_pkg::ALIAS_FIRST + {7'b0, b_base[19:0], 5'b0}
                          + {6'b0, b_size[20:0], 5'b0} - 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_blk     <= blk_c;
            r_t2_last <= r_t1_last;
        end
        if (rd_en) begin
            r_t1_last <= issue_last;
        end
        if (in_acc && is_check) begin
            r_w_first <= i_window_base;
            r_w_last  <= w_end[31:0];
        end
    end

    // compare stage
    logic hit_direct, hit_alias, hit_now;

    assign hit_direct = r_blk.live && (r_w_first <= r_blk.last) && (r_blk.first <= r_w_last);
    assign hit_alias  = r_blk.live && r_bitband && r_blk.in_region
                        && (r_w_first <= r_blk.a_last) && (r_blk.a_first <= r_w_last);
    assign hit_now    = r_v2 && (hit_direct || hit_alias);

    assign rd_en      = (r_state == ST_SCAN) && (r_issue < r_count) && !hit_now;
    assign issue_last = (r_issue == (r_count - CNT_W'(1)));
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_issue      = r_issue;
        n_count      = r_count;
        n_v1         = 1'b0;
        n_v2         = 1'b0;
        n_reason     = r_reason;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_reason = r_out_reason;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && is_check) begin
                    n_issue = '0;
                    n_count = eff_count;
                    if (i_window_size == '0) begin
                        n_reason = rwoc_pkg::REASON_NONE;
                        n_state  = ST_FIN;
                    end else if (w_end[32]) begin
                        n_reason = rwoc_pkg::REASON_WRAP;
                        n_state  = ST_FIN;
                    end else if (eff_count == '0) begin
                        n_reason = rwoc_pkg::REASON_NONE;
                        n_state  = ST_FIN;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit_now) begin
                    n_reason = hit_direct ? rwoc_pkg::REASON_DIRECT : rwoc_pkg::REASON_ALIAS;
                    n_state  = ST_FIN;
                end else if (r_v2 && r_t2_last) begin
                    n_reason = rwoc_pkg::REASON_NONE;
                    n_state  = ST_FIN;
                end else begin
                    n_v1 = rd_en;
                    n_v2 = r_v1;
                    if (rd_en) begin
                        n_issue = r_issue + CNT_W'(1);
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_reason = r_reason;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue     <= '0;
            r_count     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_reason    <= rwoc_pkg::REASON_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_count     <= n_count;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_reason    <= n_reason;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_reason <= n_out_reason;
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit_reason    = r_out_reason;
    assign o_hits_reserved = (r_out_reason != rwoc_pkg::REASON_NONE);

    // a compare slot is only filled from a bound stage that was valid the cycle before
    a_v2_follows_v1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("compare stage filled without a table read");

    // wrapping windows must never reach the table walk
    a_scan_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_w_last >= r_w_first))
        else $error("wrapping window entered the table walk");

    // a walk is only started over a nonempty table
    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_count != '0))
        else $error("table walk with no entries");

endmodule
